FILE: rtl/ucar_pkg.sv
package ucar_pkg;

	// widths and defaults
	localparam int ADC_WIDTH_DEF = 12;
	localparam int TIMEOUT_W     = 16;
	localparam int BYTE_W        = 8;
	localparam int EV_W          = 4;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd3000;
	localparam logic [BYTE_W-1:0]    BAD_MAX     = 8'd255;

	// characters of the command set
	localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
	localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
	localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
	localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_K    = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
	localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
	localparam logic [BYTE_W-1:0] CH_T    = 8'h54;

	// command recognizer states
	typedef enum logic [7:0] {
		PS_BEFORE = 8'b0000_0001,
		PS_START  = 8'b0000_0010,
		PS_O      = 8'b0000_0100,
		PS_K      = 8'b0000_1000,
		PS_R      = 8'b0001_0000,
		PS_S      = 8'b0010_0000,
		PS_T      = 8'b0100_0000,
		PS_WRONG  = 8'b1000_0000
	} ps_t;

	// pending command
	typedef enum logic [1:0] {
		PC_NONE = 2'd0,
		PC_OK   = 2'd1,
		PC_RST  = 2'd2
	} pc_t;

	// link states
	typedef enum logic [2:0] {
		LS_IDLE     = 3'b001,
		LS_WAIT_RST = 3'b010,
		LS_WAIT_OK  = 3'b100
	} ls_t;

	// result events
	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 4'd0,
		EV_READY    = 4'd1,
		EV_OK_SEEN  = 4'd2,
		EV_RST_SEEN = 4'd3,
		EV_UNKNOWN  = 4'd4,
		EV_REPORT   = 4'd5,
		EV_FAILED   = 4'd6,
		EV_DONE     = 4'd7,
		EV_RETX     = 4'd8,
		EV_RESTART  = 4'd9
	} ev_t;

endpackage

FILE: rtl/ucar_if.sv
// input channel: command byte or timer tick
interface ucar_in_if #(
	parameter int ADC_WIDTH = ucar_pkg::ADC_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [7:0]           rx_byte;
	logic [ADC_WIDTH-1:0] adc_sample;
	logic                 adc_ok;

	modport source (output valid, func, rx_byte, adc_sample, adc_ok, input ready);
	modport sink (input valid, func, rx_byte, adc_sample, adc_ok, output ready);
endinterface

// result channel
interface ucar_out_if #(
	parameter int ADC_WIDTH = ucar_pkg::ADC_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic [3:0]           event_res;
	logic [ADC_WIDTH-1:0] report_value;
	logic                 led_on;

	modport source (output valid, event_res, report_value, led_on, input ready);
	modport sink (input valid, event_res, report_value, led_on, output ready);
endinterface

FILE: rtl/ucar_parser.sv
module ucar_parser
	import ucar_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_en,
	input  logic [BYTE_W-1:0] rx_byte,
	output ev_t               ev
);

	ps_t               ps_q, ps_d;
	ps_t               good_q, good_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d;
	logic [BYTE_W-1:0] cnt_dec;
	logic              bs;

	assign bs      = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

	// next recognizer state for one byte
	always_comb begin
		ps_d   = ps_q;
		good_d = good_q;
		cnt_d  = cnt_q;
		ev     = EV_NONE;
		case (ps_q)
			PS_BEFORE: begin
				if (rx_byte == CH_BANG) begin
					ps_d   = PS_START;
					good_d = PS_START;
					cnt_d  = '0;
				end
			end
			PS_START: begin
				if (bs) begin
					ps_d   = PS_BEFORE;
					good_d = PS_BEFORE;
				end else if (rx_byte == CH_HASH) begin
					ev    = EV_UNKNOWN;
					ps_d  = PS_BEFORE;
					cnt_d = '0;
				end else if (rx_byte == CH_O) begin
					ps_d   = PS_O;
					good_d = PS_O;
				end else if (rx_byte == CH_R) begin
					ps_d   = PS_R;
					good_d = PS_R;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_O: begin
				if (bs) begin
					ps_d   = PS_START;
					good_d = PS_START;
				end else if (rx_byte == CH_K) begin
					ps_d   = PS_K;
					good_d = PS_K;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_K: begin
				if (bs) begin
					ps_d   = PS_O;
					good_d = PS_O;
				end else if (rx_byte == CH_HASH) begin
					ev   = EV_OK_SEEN;
					ps_d = PS_BEFORE;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_R: begin
				if (bs) begin
					ps_d   = PS_START;
					good_d = PS_START;
				end else if (rx_byte == CH_S) begin
					ps_d   = PS_S;
					good_d = PS_S;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_S: begin
				if (bs) begin
					ps_d   = PS_R;
					good_d = PS_R;
				end else if (rx_byte == CH_T) begin
					ps_d   = PS_T;
					good_d = PS_T;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_T: begin
				if (bs) begin
					ps_d   = PS_S;
					good_d = PS_S;
				end else if (rx_byte == CH_HASH) begin
					ev   = EV_RST_SEEN;
					ps_d = PS_BEFORE;
				end else begin
					ps_d  = PS_WRONG;
					cnt_d = 8'd1;
				end
			end
			PS_WRONG: begin
				// backspace undoes wrong characters, back to last good state at zero
				if (bs) begin
					cnt_d = cnt_dec;
					if (cnt_dec == '0) begin
						ps_d = good_q;
					end
				end else if (rx_byte == CH_HASH) begin
					ev    = EV_UNKNOWN;
					ps_d  = PS_BEFORE;
					cnt_d = '0;
				end else if (cnt_q != BAD_MAX) begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				ps_d = PS_BEFORE;
			end
		endcase
	end

	// recognizer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q   <= PS_BEFORE;
			good_q <= PS_BEFORE;
			cnt_q  <= '0;
		end else if (byte_en) begin
			ps_q   <= ps_d;
			good_q <= good_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

FILE: rtl/uart_command_adc_reporter_core.sv
// result: each item passes the input register and then the result register before its
//   result is offered on the output channel
// throughput: one item per cycle unless out_ch stalls; the state update for each item is
//   a single pass of recognizer and link logic between the input and result registers
// reset: arst_n clears recognizer, pending command, link state, tick counter, last value,
//   LED and both pipeline valids; timeout_q returns to 3000
module uart_command_adc_reporter_core
	import ucar_pkg::*;
#(
	parameter int ADC_WIDTH = ADC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ucar_in_if.sink              in_ch,
	ucar_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata
);

	logic [TIMEOUT_W-1:0] timeout_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic [ADC_WIDTH-1:0] sample_s1;
	logic                 ok_s1;

	logic                 valid_s2;
	ev_t                  ev_s2;
	logic [ADC_WIDTH-1:0] val_s2;
	logic                 led_s2;

	pc_t                  pc_q, pc_d;
	ls_t                  ls_q, ls_d;
	logic [TIMEOUT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [ADC_WIDTH-1:0] last_q, last_d;
	logic                 led_q, led_d;

	ev_t                  parse_ev;
	ev_t                  ev;
	logic [ADC_WIDTH-1:0] val;
	logic                 adv;
	logic                 step;

	// pipeline flow
	assign adv          = out_ch.ready || !valid_s2;
	assign step         = valid_s1 && adv;
	assign in_ch.ready  = !valid_s1 || adv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1   <= in_ch.func;
			byte_s1   <= in_ch.rx_byte;
			sample_s1 <= in_ch.adc_sample;
			ok_s1     <= in_ch.adc_ok;
		end
	end

	// command recognizer
	ucar_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (step && !func_s1),
		.rx_byte (byte_s1),
		.ev      (parse_ev)
	);

	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;

	// link step and pending command
	always_comb begin
		pc_d      = pc_q;
		ls_d      = ls_q;
		elapsed_d = elapsed_q;
		last_d    = last_q;
		led_d     = led_q;
		ev        = EV_NONE;
		val       = '0;
		if (!func_s1) begin
			ev = parse_ev;
			if (parse_ev == EV_OK_SEEN) begin
				pc_d = PC_OK;
			end else if (parse_ev == EV_RST_SEEN) begin
				pc_d = PC_RST;
			end
		end else begin
			case (ls_q)
				LS_WAIT_RST: begin
					if (pc_q == PC_OK) begin
						pc_d  = PC_NONE;
						led_d = 1'b0;
						ev    = EV_DONE;
					end else if (pc_q == PC_RST) begin
						pc_d = PC_NONE;
						if (ok_s1) begin
							last_d = sample_s1;
							val    = sample_s1;
							ev     = EV_REPORT;
						end else begin
							ev = EV_FAILED;
						end
						ls_d      = LS_WAIT_OK;
						elapsed_d = '0;
						led_d     = 1'b1;
					end
				end
				LS_WAIT_OK: begin
					if (pc_q == PC_RST) begin
						ls_d = LS_WAIT_RST;
						ev   = EV_RESTART;
					end else if (pc_q == PC_OK) begin
						pc_d  = PC_NONE;
						ls_d  = LS_WAIT_RST;
						led_d = 1'b0;
						ev    = EV_DONE;
					end else if (elapsed_inc >= timeout_q) begin
						val       = last_q;
						elapsed_d = '0;
						ev        = EV_RETX;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				default: begin
					ls_d = LS_WAIT_RST;
					ev   = EV_READY;
				end
			endcase
		end
	end

	// link state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_NONE;
			ls_q      <= LS_IDLE;
			elapsed_q <= '0;
			last_q    <= '0;
			led_q     <= 1'b0;
		end else if (step) begin
			pc_q      <= pc_d;
			ls_q      <= ls_d;
			elapsed_q <= elapsed_d;
			last_q    <= last_d;
			led_q     <= led_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2  <= ev;
			val_s2 <= val;
			led_s2 <= led_d;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.event_res    = ev_s2;
	assign out_ch.report_value = val_s2;
	assign out_ch.led_on       = led_s2;

	// a held input item stays until the result side frees up
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input stage dropped a held item");

	// a report, failed read or retransmit always shows the LED lit
	a_led_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (ev_s2 == EV_REPORT || ev_s2 == EV_FAILED || ev_s2 == EV_RETX)
		|-> led_s2)
		else $error("busy event without LED");

	// the ready announcement comes before any exchange, so the LED is off
	a_ready_dark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ev_s2 == EV_READY |-> !led_s2)
		else $error("ready announced with LED lit");

	// only waiting for OK lets the tick counter run up
	a_wait_ok: assert property (@(posedge clk) disable iff (!arst_n)
		step && func_s1 && ev == EV_RETX |-> ls_q == LS_WAIT_OK)
		else $error("retransmit outside of waiting for OK");

endmodule
